FILE: hw/rtl/faa_pkg.sv
// Types, codes and size-class arithmetic shared by the fragment allocation accountant.
package faa_pkg;

    localparam int unsigned MAX_FRAGMENTS_BOUND = 1024;
    localparam int unsigned CNT_W   = 11;
    localparam int unsigned IDX_W   = 3;
    localparam logic [31:0] POOL_TOP   = 32'd16384;
    localparam logic [31:0] MIN_CELL   = 32'd8;
    localparam logic [32:0] ALIGN_MASK = 33'h1_FFFF_FFF0;

    typedef enum logic [1:0] {
        ACT_APPEND  = 2'd0,
        ACT_ATTACH  = 2'd1,
        ACT_RESERVE = 2'd2,
        ACT_FINISH  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_CLOSED    = 2'd1,
        ST_EXHAUSTED = 2'd2,
        ST_RANGE     = 2'd3
    } status_t;

    localparam logic [IDX_W-1:0] REG_INIT_SIZE = 3'd0;
    localparam logic [IDX_W-1:0] REG_CEILING   = 3'd1;
    localparam logic [IDX_W-1:0] REG_TOTAL_LIM = 3'd2;
    localparam logic [IDX_W-1:0] REG_FRAG_LIM  = 3'd3;
    localparam logic [IDX_W-1:0] REG_RET_LIM   = 3'd4;
    localparam logic [IDX_W-1:0] REG_PACK_THR  = 3'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] length;
    } request_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      total_bytes;
        logic [31:0]      retained_total;
        logic [CNT_W-1:0] fragments;
        logic [31:0]      tail_free;
        logic [31:0]      latest_allocation;
    } result_t;

    // Allocator size class of sz (sz >= 8), given lg = floor(log2(sz)).
    function automatic logic [32:0] size_class(input logic [31:0] sz, input logic [4:0] lg);
        logic [32:0] span;
        logic [31:0] frac;
        logic [6:0]  idx;
        logic [32:0] served;
        span   = 33'd1 << lg;
        frac   = (sz - 32'd1) >> (lg - 5'd2);
        idx    = 7'({lg, 2'b00}) - 7'd3 + frac[6:0];
        served = (33'({1'b1, idx[1:0]}) << idx[6:2]) >> 2;
        if (sz > POOL_TOP) begin
            size_class = (span == {1'b0, sz}) ? {1'b0, sz} : (span << 1);
        end else if (served > 33'd16) begin
            size_class = (served + 33'd15) & ALIGN_MASK;
        end else begin
            size_class = served;
        end
    endfunction

endpackage

FILE: hw/rtl/fragment_allocation_accountant_top.sv
// Fragment allocation accountant: sequencer with one shared grow/size-class unit.
//
//  channel | signals                          | transfer when
//  --------+----------------------------------+---------------------------
//  request | start, busy, request             | start & !busy
//  result  | done, result                     | done (one cycle, no stall)
//  config  | cfg_valid, cfg_ready, cfg_index, | cfg_valid & cfg_ready
//          | cfg_data                         | (cfg_ready always high)
//
// An append alternates tail fills with grows until its length is placed; attach
// and reserve grow at most once. All grows run through one shared unit (prep,
// 5-step log2 search, class, commit). Finish answers straight from the check
// state; every other request, a closed one too, answers from the emit state.
// Reset sets the registers to their defaults and clears the accounting at once;
// no clearing pass.
module fragment_allocation_accountant_top
    import faa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  request_t         request,
    output logic             done,
    output result_t          result,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [31:0]      cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHECK, S_APP, S_GPREP, S_GLG, S_GCLS, S_GCOMMIT, S_ATTFILL, S_EMIT
    } state_t;

    typedef enum logic [1:0] {
        RET_APP, RET_ATT, RET_RES
    } ret_t;

    state_t state_reg;
    ret_t   ret_reg;

    logic [31:0]      init_reg, ceil_reg, tlim_reg, rlim_reg, pack_reg;
    logic [CNT_W-1:0] flim_reg;

    logic [31:0]      logical_reg, retained_reg, tail_reg, prev_reg;
    logic [CNT_W-1:0] count_reg, nonempty_reg;
    logic             hasdata_reg, closed_reg;

    logic [31:0]      w_logical_reg, w_retained_reg, w_tail_reg, w_prev_reg;
    logic [CNT_W-1:0] w_count_reg, w_nonempty_reg;
    logic             w_hasdata_reg;

    logic [1:0]  act_reg;
    logic [31:0] len_reg, left_reg, need_reg, target_reg, sz_reg, alloc_reg;
    logic [4:0]  lg_reg;
    logic [2:0]  step_reg;
    status_t     status_reg;
    result_t     result_reg;
    logic        done_reg;

    logic [CNT_W-1:0] cap;
    logic [32:0]      sum_total, cand_grow, cand, target, served, ret_sum, big_ret;
    logic [4:0]       trial;
    logic [31:0]      take;

    always_comb
    begin
        cap       = (flim_reg > CNT_W'(MAX_FRAGMENTS_BOUND)) ? CNT_W'(MAX_FRAGMENTS_BOUND)
                                                             : flim_reg;
        sum_total = {1'b0, logical_reg} + {1'b0, len_reg};
        big_ret   = {1'b0, retained_reg} + {1'b0, len_reg};
        cand_grow = {1'b0, w_prev_reg} + {2'b00, w_prev_reg[31:1]};
        cand      = (w_prev_reg == 32'd0) ? {1'b0, init_reg} : cand_grow;
        if (cand > {1'b0, ceil_reg}) cand = {1'b0, ceil_reg};
        target    = (cand > {1'b0, need_reg}) ? cand : {1'b0, need_reg};
        if (target > {1'b0, ceil_reg}) target = {1'b0, ceil_reg};
        trial     = lg_reg | (5'd1 << step_reg);
        served    = (target_reg == 32'd0) ? 33'd0 : size_class(sz_reg, lg_reg);
        ret_sum   = {1'b0, w_retained_reg} + {1'b0, alloc_reg};
        take      = (w_tail_reg < left_reg) ? w_tail_reg : left_reg;
    end

    assign busy      = (state_reg != S_IDLE);
    assign done      = done_reg;
    assign result    = result_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            ret_reg       <= RET_APP;
            init_reg      <= 32'd512;
            ceil_reg      <= 32'd131072;
            tlim_reg      <= 32'd4194304;
            flim_reg      <= CNT_W'(16);
            rlim_reg      <= 32'd8388608;
            pack_reg      <= 32'd512;
            logical_reg   <= '0;
            retained_reg  <= '0;
            tail_reg      <= '0;
            prev_reg      <= '0;
            count_reg     <= '0;
            nonempty_reg  <= '0;
            hasdata_reg   <= 1'b0;
            closed_reg    <= 1'b0;
            done_reg      <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (cfg_valid) begin
                case (cfg_index)
                    REG_INIT_SIZE: init_reg <= cfg_data;
                    REG_CEILING:   ceil_reg <= cfg_data;
                    REG_TOTAL_LIM: tlim_reg <= cfg_data;
                    REG_FRAG_LIM:  flim_reg <= cfg_data[CNT_W-1:0];
                    REG_RET_LIM:   rlim_reg <= cfg_data;
                    REG_PACK_THR:  pack_reg <= cfg_data;
                    default: ;
                endcase
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (start) begin
                        act_reg   <= request.action;
                        len_reg   <= request.length;
                        state_reg <= S_CHECK;
                    end
                end
                S_CHECK:
                begin
                    w_logical_reg  <= logical_reg;
                    w_retained_reg <= retained_reg;
                    w_tail_reg     <= tail_reg;
                    w_prev_reg     <= prev_reg;
                    w_count_reg    <= count_reg;
                    w_nonempty_reg <= nonempty_reg;
                    w_hasdata_reg  <= hasdata_reg;
                    left_reg       <= len_reg;
                    need_reg       <= len_reg;
                    status_reg     <= ST_OK;
                    state_reg      <= S_EMIT;
                    if (closed_reg) begin
                        status_reg <= ST_CLOSED;
                    end else begin
                        case (act_reg)
                            ACT_FINISH:
                            begin
                                result_reg <= '{ST_OK, logical_reg, retained_reg,
                                                nonempty_reg, 32'd0, 32'd0};
                                done_reg     <= 1'b1;
                                logical_reg  <= '0;
                                retained_reg <= '0;
                                tail_reg     <= '0;
                                prev_reg     <= '0;
                                count_reg    <= '0;
                                nonempty_reg <= '0;
                                hasdata_reg  <= 1'b0;
                                closed_reg   <= 1'b1;
                                state_reg    <= S_IDLE;
                            end
                            ACT_APPEND:
                            begin
                                if (sum_total > {1'b0, tlim_reg}) status_reg <= ST_EXHAUSTED;
                                else state_reg <= S_APP;
                            end
                            ACT_ATTACH:
                            begin
                                if (sum_total > {1'b0, tlim_reg}) begin
                                    status_reg <= ST_EXHAUSTED;
                                end else if (len_reg == 32'd0) begin
                                    status_reg <= ST_OK;
                                end else if (len_reg <= pack_reg && len_reg <= ceil_reg) begin
                                    ret_reg   <= RET_ATT;
                                    state_reg <= (tail_reg < len_reg) ? S_GPREP : S_ATTFILL;
                                end else if (count_reg >= cap
                                             || big_ret > {1'b0, rlim_reg}) begin
                                    status_reg <= ST_EXHAUSTED;
                                end else begin
                                    // large fragment linked as its own, full
                                    count_reg    <= count_reg + CNT_W'(1);
                                    retained_reg <= big_ret[31:0];
                                    tail_reg     <= '0;
                                    hasdata_reg  <= 1'b1;
                                    nonempty_reg <= nonempty_reg + CNT_W'(1);
                                    logical_reg  <= sum_total[31:0];
                                end
                            end
                            default:
                            begin
                                if (len_reg == 32'd0) status_reg <= ST_OK;
                                else if (len_reg > ceil_reg) status_reg <= ST_RANGE;
                                else if (sum_total > {1'b0, tlim_reg})
                                    status_reg <= ST_EXHAUSTED;
                                else if (tail_reg >= len_reg) status_reg <= ST_OK;
                                else begin
                                    ret_reg   <= RET_RES;
                                    state_reg <= S_GPREP;
                                end
                            end
                        endcase
                    end
                end
                S_APP:
                begin
                    if (left_reg == 32'd0) begin
                        logical_reg  <= w_logical_reg;
                        retained_reg <= w_retained_reg;
                        tail_reg     <= w_tail_reg;
                        prev_reg     <= w_prev_reg;
                        count_reg    <= w_count_reg;
                        nonempty_reg <= w_nonempty_reg;
                        hasdata_reg  <= w_hasdata_reg;
                        state_reg    <= S_EMIT;
                    end else if (w_tail_reg == 32'd0) begin
                        need_reg  <= left_reg;
                        ret_reg   <= RET_APP;
                        state_reg <= S_GPREP;
                    end else begin
                        w_tail_reg    <= w_tail_reg - take;
                        w_logical_reg <= w_logical_reg + take;
                        left_reg      <= left_reg - take;
                        if (!w_hasdata_reg) begin
                            w_hasdata_reg  <= 1'b1;
                            w_nonempty_reg <= w_nonempty_reg + CNT_W'(1);
                        end
                    end
                end
                S_GPREP:
                begin
                    if (w_count_reg >= cap) begin
                        status_reg <= ST_EXHAUSTED;
                        state_reg  <= S_EMIT;
                    end else begin
                        target_reg <= target[31:0];
                        sz_reg     <= (target[31:0] < MIN_CELL) ? MIN_CELL : target[31:0];
                        lg_reg     <= '0;
                        step_reg   <= 3'd4;
                        state_reg  <= S_GLG;
                    end
                end
                S_GLG:
                begin
                    // successive approximation of floor(log2(sz)), one bit a cycle
                    if ((sz_reg >> trial) != 32'd0) lg_reg <= trial;
                    step_reg <= step_reg - 3'd1;
                    if (step_reg == 3'd0) state_reg <= S_GCLS;
                end
                S_GCLS:
                begin
                    alloc_reg <= (served <= {1'b0, ceil_reg}) ? served[31:0] : target_reg;
                    state_reg <= S_GCOMMIT;
                end
                S_GCOMMIT:
                begin
                    if (alloc_reg == 32'd0 || ret_sum > {1'b0, rlim_reg}) begin
                        status_reg <= ST_EXHAUSTED;
                        state_reg  <= S_EMIT;
                    end else begin
                        w_count_reg    <= w_count_reg + CNT_W'(1);
                        w_retained_reg <= ret_sum[31:0];
                        w_tail_reg     <= alloc_reg;
                        w_hasdata_reg  <= 1'b0;
                        w_prev_reg     <= alloc_reg;
                        case (ret_reg)
                            RET_APP: state_reg <= S_APP;
                            RET_ATT: state_reg <= S_ATTFILL;
                            default:
                            begin
                                retained_reg <= ret_sum[31:0];
                                count_reg    <= w_count_reg + CNT_W'(1);
                                tail_reg     <= alloc_reg;
                                hasdata_reg  <= 1'b0;
                                prev_reg     <= alloc_reg;
                                state_reg    <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_ATTFILL:
                begin
                    logical_reg  <= w_logical_reg + len_reg;
                    tail_reg     <= w_tail_reg - len_reg;
                    retained_reg <= w_retained_reg;
                    prev_reg     <= w_prev_reg;
                    count_reg    <= w_count_reg;
                    hasdata_reg  <= 1'b1;
                    nonempty_reg <= w_hasdata_reg ? w_nonempty_reg
                                                  : w_nonempty_reg + CNT_W'(1);
                    state_reg    <= S_EMIT;
                end
                S_EMIT:
                begin
                    result_reg <= '{status_reg, logical_reg, retained_reg, count_reg,
                                    tail_reg, prev_reg};
                    done_reg   <= 1'b1;
                    state_reg  <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: test/fragment_allocation_accountant_top_tb.sv
// Self-checking testbench for the fragment allocation accountant.
`timescale 1ns / 1ps

module fragment_allocation_accountant_top_tb
    import faa_pkg::*;
();

    localparam logic [IDX_W-1:0] REG_UNUSED = 3'd7;
    localparam int unsigned STALL_LIMIT = 100000;

    typedef struct {
        longint unsigned logical;
        longint unsigned retained;
        int unsigned     frag_cnt;
        int unsigned     nonempty;
        longint unsigned tail_space;
        bit              holds_bytes;
        longint unsigned prev_grow;
        bit              closed;
    } ledger_t;

    class ledger_scoreboard;
        longint unsigned init_size = 512;
        longint unsigned ceiling = 131072;
        longint unsigned total_lim = 4194304;
        longint unsigned frag_lim = 16;
        longint unsigned ret_lim = 8388608;
        longint unsigned pack_thr = 512;
        ledger_t cur;
        ledger_t work;
        result_t pending[$];
        int errors = 0;

        function void set_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
            case (idx)
                REG_INIT_SIZE: init_size = val;
                REG_CEILING:   ceiling = val;
                REG_TOTAL_LIM: total_lim = val;
                REG_FRAG_LIM:  frag_lim = val[CNT_W-1:0];
                REG_RET_LIM:   ret_lim = val;
                REG_PACK_THR:  pack_thr = val;
                default: ;
            endcase
        endfunction

        function longint unsigned alloc_class(longint unsigned sz);
            int unsigned lg;
            longint unsigned idx, served, span;
            if (sz == 0)
                return 0;
            if (sz < 8)
                sz = 8;
            lg = 0;
            while (lg < 63 && (sz >> (lg + 1)) != 0)
                lg++;
            if (sz > 16384)
            begin
                span = 64'd1 << lg;
                return (span == sz || lg >= 63) ? sz : span << 1;
            end
            idx = ((longint'(lg) << 2) - 3) + ((sz - 1) >> (lg - 2));
            served = ((4 | (idx & 3)) << (idx >> 2)) >> 2;
            if (served > 16)
                served = (served + 15) / 16 * 16;
            return served;
        endfunction

        function int unsigned cap();
            return (frag_lim > MAX_FRAGMENTS_BOUND) ? MAX_FRAGMENTS_BOUND : int'(frag_lim);
        endfunction

        // New tail fragment in the working copy; 0 when a limit forbids it
        function bit new_fragment(longint unsigned need);
            longint unsigned cand, tgt, served, alloc;
            if (work.frag_cnt >= cap())
                return 0;
            cand = (work.prev_grow != 0) ? work.prev_grow + work.prev_grow / 2 : init_size;
            if (cand > ceiling)
                cand = ceiling;
            tgt = (cand > need) ? cand : need;
            if (tgt > ceiling)
                tgt = ceiling;
            served = alloc_class(tgt);
            alloc = (served <= ceiling) ? served : tgt;
            if (alloc == 0 || work.retained + alloc > ret_lim)
                return 0;
            work.frag_cnt++;
            work.retained += alloc;
            work.tail_space = alloc;
            work.holds_bytes = 0;
            work.prev_grow = alloc;
            return 1;
        endfunction

        function void fill(longint unsigned n);
            work.tail_space -= n;
            work.logical += n;
            if (n != 0 && !work.holds_bytes)
            begin
                work.holds_bytes = 1;
                work.nonempty++;
            end
        endfunction

        function status_t apply(action_t act, longint unsigned len);
            longint unsigned left, take;
            work = cur;
            if (act != ACT_RESERVE && cur.logical + len > total_lim)
                return ST_EXHAUSTED;
            case (act)
                ACT_APPEND:
                begin
                    left = len;
                    while (left != 0)
                    begin
                        if (work.tail_space == 0 && !new_fragment(left))
                            return ST_EXHAUSTED;
                        take = (work.tail_space < left) ? work.tail_space : left;
                        fill(take);
                        left -= take;
                    end
                end
                ACT_ATTACH:
                begin
                    if (len == 0)
                        return ST_OK;
                    if (len <= pack_thr && len <= ceiling)
                    begin
                        if (work.tail_space < len && !new_fragment(len))
                            return ST_EXHAUSTED;
                        fill(len);
                    end
                    else
                    begin
                        if (work.frag_cnt >= cap() || work.retained + len > ret_lim)
                            return ST_EXHAUSTED;
                        work.frag_cnt++;
                        work.retained += len;
                        work.tail_space = 0;
                        work.holds_bytes = 1;
                        work.nonempty++;
                        work.logical += len;
                    end
                end
                default:
                begin
                    if (len == 0)
                        return ST_OK;
                    if (len > ceiling)
                        return ST_RANGE;
                    if (cur.logical + len > total_lim)
                        return ST_EXHAUSTED;
                    if (work.tail_space >= len)
                        return ST_OK;
                    if (!new_fragment(len))
                        return ST_EXHAUSTED;
                end
            endcase
            cur = work;
            return ST_OK;
        endfunction

        function void note(request_t req);
            result_t r;
            ledger_t blank;
            if (cur.closed)
                r.status = ST_CLOSED;
            else if (action_t'(req.action) == ACT_FINISH)
            begin
                r.status = ST_OK;
                r.total_bytes = cur.logical[31:0];
                r.retained_total = cur.retained[31:0];
                r.fragments = cur.nonempty[CNT_W-1:0];
                r.tail_free = '0;
                r.latest_allocation = '0;
                blank = '{default: 0};
                cur = blank;
                cur.closed = 1;
                pending.insert(pending.size(), r);
                return;
            end
            else
                r.status = apply(action_t'(req.action), req.length);
            r.total_bytes = cur.logical[31:0];
            r.retained_total = cur.retained[31:0];
            r.fragments = cur.frag_cnt[CNT_W-1:0];
            r.tail_free = cur.tail_space[31:0];
            r.latest_allocation = cur.prev_grow[31:0];
            pending.insert(pending.size(), r);
        endfunction

        function void field(string name, longint unsigned exp_v, longint unsigned act_v);
            if (exp_v != act_v)
            begin
                $error("%s: expected %0d, got %0d", name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check(result_t got);
            result_t exp_r;
            if (pending.size() == 0)
            begin
                $error("result with nothing outstanding");
                errors++;
                return;
            end
            exp_r = pending.pop_front();
            field("status", exp_r.status, got.status);
            field("total_bytes", exp_r.total_bytes, got.total_bytes);
            field("retained_total", exp_r.retained_total, got.retained_total);
            field("fragments", exp_r.fragments, got.fragments);
            field("tail_free", exp_r.tail_free, got.tail_free);
            field("latest_allocation", exp_r.latest_allocation, got.latest_allocation);
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             start = 1'b0;
    logic             busy;
    request_t         request = '0;
    logic             done;
    result_t          result;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [31:0]      cfg_data = '0;

    ledger_scoreboard ledger = new();
    int unsigned      quiet_cycles = 0;
    int unsigned      gap_pct = 0;

    fragment_allocation_accountant_top dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (done)
            ledger.check(result);
        if (done || (start && !busy))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // start is left high so back-to-back transfers need no toggle
    task automatic send(action_t act, logic [31:0] len);
        request_t req;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        req.action = act;
        req.length = len;
        start <= 1'b1;
        request <= req;
        do
            @(posedge clk);
        while (busy);
        ledger.note(req);
    endtask

    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (ledger.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(logic [IDX_W-1:0] idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        ledger.set_reg(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic setup(logic [31:0] init_sz, logic [31:0] ceil_sz, logic [31:0] tot,
                         logic [31:0] frags, logic [31:0] ret, logic [31:0] pack);
        write_reg(REG_INIT_SIZE, init_sz);
        write_reg(REG_CEILING, ceil_sz);
        write_reg(REG_TOTAL_LIM, tot);
        write_reg(REG_FRAG_LIM, frags);
        write_reg(REG_RET_LIM, ret);
        write_reg(REG_PACK_THR, pack);
    endtask

    function automatic logic [31:0] pick_length();
        case ($urandom_range(0, 9))
            0:       return 32'd0;
            1, 2, 3, 4, 5: return $urandom_range(1, 600);
            6, 7:    return $urandom_range(1, 70000);
            8:       return $urandom_range(1, 2000000);
            default: return $urandom;
        endcase
    endfunction

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(REG_UNUSED, 32'hFFFF_FFFF);
        setup(512, 131072, 4194304, 16, 8388608, 512);
        send(ACT_APPEND, 0);
        send(ACT_ATTACH, 0);
        send(ACT_RESERVE, 0);
        send(ACT_APPEND, 1);
        send(ACT_APPEND, 32'hFFFF_FFFF);
        send(ACT_ATTACH, 513);
        send(ACT_ATTACH, 512);
        send(ACT_RESERVE, 131073);
        send(ACT_RESERVE, 131072);
        send(ACT_APPEND, 100000);
        send(ACT_ATTACH, 32'hFFFF_FFFF);
        send(ACT_RESERVE, 32'hFFFF_FFFF);
        drain();
        // zero ceiling: every growth has size zero
        write_reg(REG_CEILING, 0);
        send(ACT_APPEND, 5000);
        send(ACT_RESERVE, 5);
        send(ACT_ATTACH, 7);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph)
                0: setup(1, 40, 4000000, 60, 32'hFFFF_FFFF, 0);
                1: setup(32'hFFFF_FFFF, 70000, 32'hFFFF_FFFF, 200, 50000000, 32'hFFFF_FFFF);
                2: setup(100, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1024, 32'hFFFF_FFFF, 1000);
                3: setup(512, 131072, 3000000, 1, 8388608, 512);
                4: setup(7, 16384, 32'hFFFF_FFFF, 1024, 32'hFFFF_FFFF, 300);
                default: setup(512, 131072, 4194304, 16, 8388608, 512);
            endcase
            gap_pct = (ph < 2) ? 38 : (ph < 4) ? 54 : 0;
            for (int n = 0; n < 125; n++)
                send(action_t'($urandom_range(0, 2)), pick_length());
            drain();
        end

        // finish closes the buffer for good, so it comes last
        send(ACT_FINISH, $urandom);
        send(ACT_APPEND, 10);
        send(ACT_ATTACH, 10);
        send(ACT_RESERVE, 10);
        send(ACT_FINISH, 0);
        drain();

        if (ledger.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
